@@ rtl/core/hsv2rgb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, pipeline depth and hue sector codes.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   localparam int HUE_BITS             = 16;
   localparam int SECTOR_BITS          = 3;
   localparam int SECTORS              = 6;
   localparam int DEFAULT_CHANNEL_BITS = 8;
   localparam int MIN_CHANNEL_BITS     = 4;
   localparam int MAX_CHANNEL_BITS     = 16;

   // Number of register stages between an accepted input word and its result.
   localparam int PIPE_STAGES = 5;

   typedef logic [SECTOR_BITS-1:0] sector_type;

   // Each sector spans 60 degrees of hue, starting at red.
   localparam sector_type SEC_RED_YELLOW    = 3'd0;
   localparam sector_type SEC_YELLOW_GREEN  = 3'd1;
   localparam sector_type SEC_GREEN_CYAN    = 3'd2;
   localparam sector_type SEC_CYAN_BLUE     = 3'd3;
   localparam sector_type SEC_BLUE_MAGENTA  = 3'd4;
   localparam sector_type SEC_MAGENTA_RED   = 3'd5;

endpackage

@@ rtl/core/hsv_to_rgb_converter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Five-stage pipeline that turns one HSV pixel into one RGB pixel.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock while the output side keeps tready
// high; its five register stages are hue scaling, saturation product,
// brightness product, rounding offset, and divide by full scale with channel
// select. Every stage holds its own valid bit, so an empty stage fills while
// the stages after it stall, and req_tready is high whenever the output
// register is empty or being taken. Hue is a fraction of a full turn (65536
// codes), saturation and brightness are fractions of 2^CHANNEL_BITS - 1, and
// results are rounded to nearest.
module hsv_to_rgb_converter_top
   import hsv2rgb_pkg::*;
#(
   parameter int CHANNEL_BITS = DEFAULT_CHANNEL_BITS,
   localparam int REQ_W = ((HUE_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // hue, saturation, brightness (zero pad)
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // red, green, blue (zero pad)
);

   localparam int CB   = CHANNEL_BITS;
   localparam int H6_W = HUE_BITS + SECTOR_BITS;
   localparam logic [CB-1:0]   CMAX = {CB{1'b1}};
   // Half of full scale rounded down; added so the divide rounds to nearest.
   localparam logic [2*CB-1:0] HALF = (2*CB)'((1 << (CB - 1)) - 1);
   localparam logic [HUE_BITS:0] HUE_ONE = {1'b1, {HUE_BITS{1'b0}}};

   logic [PIPE_STAGES-1:0] valid_ff, valid_in, stage_ready;

   // Stage 1: hue scaled by six, split into sector and fraction.
   logic [HUE_BITS-1:0] hue;
   logic [CB-1:0]       sat, bri;
   logic [H6_W-1:0]     hue6;
   sector_type          st1_sector_ff;
   logic [HUE_BITS-1:0] st1_frac_ff;
   logic [CB-1:0]       st1_sat_ff, st1_bri_ff;

   // Stage 2: complements of the saturation terms.
   logic [CB+HUE_BITS-1:0] prod_q;
   logic [CB+HUE_BITS-1:0] prod_t;
   logic [HUE_BITS:0]      frac_rest;
   sector_type             st2_sector_ff;
   logic                   st2_grey_ff;
   logic [CB-1:0]          st2_bri_ff, st2_cp_ff, st2_cq_ff, st2_ct_ff;

   // Stage 3: brightness products.
   sector_type      st3_sector_ff;
   logic            st3_grey_ff;
   logic [CB-1:0]   st3_bri_ff;
   logic [2*CB-1:0] st3_np_ff, st3_nq_ff, st3_nt_ff;

   // Stage 4: rounding offset added.
   sector_type      st4_sector_ff;
   logic            st4_grey_ff;
   logic [CB-1:0]   st4_bri_ff;
   logic [2*CB-1:0] st4_yp_ff, st4_yq_ff, st4_yt_ff;

   // Stage 5: divided by full scale and placed in the channels.
   logic [2*CB-1:0] sum_p, sum_q, sum_t;
   logic [CB-1:0]   chan_p, chan_q, chan_t;
   logic [CB-1:0]   red_in, green_in, blue_in;
   logic [CB-1:0]   red_ff, green_ff, blue_ff;

   // A stage may load when it is empty or its word moves on this cycle.
   always_comb begin
      stage_ready[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_tready;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[0] = stage_ready[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < PIPE_STAGES; k++) begin
         valid_in[k] = stage_ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_ready[0];
   assign rsp_tvalid = valid_ff[PIPE_STAGES-1];
   assign rsp_tdata  = RSP_W'({blue_ff, green_ff, red_ff});

   assign hue  = req_tdata[HUE_BITS-1:0];
   assign sat  = req_tdata[HUE_BITS+CB-1:HUE_BITS];
   assign bri  = req_tdata[HUE_BITS+2*CB-1:HUE_BITS+CB];
   assign hue6 = H6_W'(hue) * H6_W'(SECTORS);

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         st1_sector_ff <= hue6[H6_W-1:HUE_BITS];
         st1_frac_ff   <= hue6[HUE_BITS-1:0];
         st1_sat_ff    <= sat;
         st1_bri_ff    <= bri;
      end
   end

   // Both scaled saturations stay at or below the saturation times a full
   // turn, so each product fits in CB+HUE_BITS bits.
   assign frac_rest = HUE_ONE - {1'b0, st1_frac_ff};
   assign prod_q    = (CB+HUE_BITS)'(st1_sat_ff) * (CB+HUE_BITS)'(st1_frac_ff);
   assign prod_t    = (CB+HUE_BITS)'(st1_sat_ff) * (CB+HUE_BITS)'(frac_rest);

   always_ff @(posedge clock) begin
      if (stage_ready[1]) begin
         st2_sector_ff <= st1_sector_ff;
         st2_grey_ff   <= (st1_sat_ff == '0);
         st2_bri_ff    <= st1_bri_ff;
         st2_cp_ff     <= CMAX - st1_sat_ff;
         st2_cq_ff     <= CMAX - prod_q[CB+HUE_BITS-1:HUE_BITS];
         st2_ct_ff     <= CMAX - prod_t[CB+HUE_BITS-1:HUE_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[2]) begin
         st3_sector_ff <= st2_sector_ff;
         st3_grey_ff   <= st2_grey_ff;
         st3_bri_ff    <= st2_bri_ff;
         st3_np_ff     <= (2*CB)'(st2_bri_ff) * (2*CB)'(st2_cp_ff);
         st3_nq_ff     <= (2*CB)'(st2_bri_ff) * (2*CB)'(st2_cq_ff);
         st3_nt_ff     <= (2*CB)'(st2_bri_ff) * (2*CB)'(st2_ct_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[3]) begin
         st4_sector_ff <= st3_sector_ff;
         st4_grey_ff   <= st3_grey_ff;
         st4_bri_ff    <= st3_bri_ff;
         st4_yp_ff     <= st3_np_ff + HALF;
         st4_yq_ff     <= st3_nq_ff + HALF;
         st4_yt_ff     <= st3_nt_ff + HALF;
      end
   end

   // Division by 2^CB - 1 of a value below 2^(2*CB): add the value shifted
   // down by CB plus one, then shift down by CB.
   assign sum_p  = st4_yp_ff + (st4_yp_ff >> CB) + (2*CB)'(1);
   assign sum_q  = st4_yq_ff + (st4_yq_ff >> CB) + (2*CB)'(1);
   assign sum_t  = st4_yt_ff + (st4_yt_ff >> CB) + (2*CB)'(1);
   assign chan_p = sum_p[2*CB-1:CB];
   assign chan_q = sum_q[2*CB-1:CB];
   assign chan_t = sum_t[2*CB-1:CB];

   always_comb begin
      if (st4_grey_ff) begin
         red_in   = st4_bri_ff;
         green_in = st4_bri_ff;
         blue_in  = st4_bri_ff;
      end else begin
         case (st4_sector_ff)
            SEC_RED_YELLOW: begin
               red_in = st4_bri_ff; green_in = chan_t;     blue_in = chan_p;
            end
            SEC_YELLOW_GREEN: begin
               red_in = chan_q;     green_in = st4_bri_ff; blue_in = chan_p;
            end
            SEC_GREEN_CYAN: begin
               red_in = chan_p;     green_in = st4_bri_ff; blue_in = chan_t;
            end
            SEC_CYAN_BLUE: begin
               red_in = chan_p;     green_in = chan_q;     blue_in = st4_bri_ff;
            end
            SEC_BLUE_MAGENTA: begin
               red_in = chan_t;     green_in = chan_p;     blue_in = st4_bri_ff;
            end
            default: begin
               red_in = st4_bri_ff; green_in = chan_p;     blue_in = chan_q;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[4]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

endmodule

@@ rtl/core/hsv2rgb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Port-level checks on flow control, latency and grey pixels.
// ----------------------------------------------------------------------------
module hsv2rgb_checker
   import hsv2rgb_pkg::*;
#(
   parameter int CHANNEL_BITS = DEFAULT_CHANNEL_BITS,
   localparam int REQ_W = ((HUE_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
)
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   localparam int CB = CHANNEL_BITS;

   logic req_word;
   logic sat_zero;
   logic [CB-1:0] bri;

   assign req_word = req_tvalid && req_tready;
   assign sat_zero = (req_tdata[HUE_BITS+CB-1:HUE_BITS] == '0);
   assign bri      = req_tdata[HUE_BITS+2*CB-1:HUE_BITS+CB];

   // A stalled result word stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // A stalled result word keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Input is taken whenever the output side is free.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled while output side is free");

   // With the output side never stalling, a grey word comes out after the
   // pipeline latency with every channel equal to its brightness.
   assert property (@(posedge clock) disable iff (reset)
      req_word && sat_zero ##1 (rsp_tready && !reset) ##1 (rsp_tready && !reset)
         ##1 (rsp_tready && !reset) ##1 (rsp_tready && !reset)
      |=> rsp_tvalid
          && rsp_tdata[CB-1:0] == $past(bri, PIPE_STAGES)
          && rsp_tdata[2*CB-1:CB] == $past(bri, PIPE_STAGES)
          && rsp_tdata[3*CB-1:2*CB] == $past(bri, PIPE_STAGES))
      else $error("grey word late or wrong");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_hsv2rgb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
